>>> design/ring_deque_with_load_sum_defines.svh
// Assertion macros used by the ring deque top level.
`ifndef RING_DEQUE_WITH_LOAD_SUM_DEFINES_SVH
`define RING_DEQUE_WITH_LOAD_SUM_DEFINES_SVH

// Checks that a condition implies another in the same cycle.
`define RDQ_ASSERT_SAME(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Checks that a condition implies another in the following cycle.
`define RDQ_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

>>> design/rdq_pkg.sv
// Package with widths, codes and stage types of the ring deque.
package rdq_pkg;

    localparam int SLOTS_DEFAULT = 64;

    localparam int FUNC_W    = 3;
    localparam int PAYLOAD_W = 32;
    localparam int UNITS_W   = 8;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 6;
    localparam int LOAD_W    = 14;
    localparam int ENTRY_W   = PAYLOAD_W + UNITS_W;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_BACK  = 3'd0,
        FN_PUSH_FRONT = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_PEEK_FRONT = 3'd4,
        FN_PEEK_BACK  = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Information that travels with one transaction from the front stage
    // to the result stage, beside the memory read data.
    typedef struct packed {
        logic                 push;
        logic                 pop;
        logic                 read;
        status_t              status;
        logic [UNITS_W-1:0]   units;
        logic [COUNT_W-1:0]   count;
    } stage_t;

endpackage

>>> design/rdq_req_if.sv
// Request channel interface of the ring deque.
interface rdq_req_if;
    import rdq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [FUNC_W-1:0]    func;
    logic [PAYLOAD_W-1:0] entry_payload;
    logic [UNITS_W-1:0]   entry_units;

    modport source (output valid, output func, output entry_payload, output entry_units,
                    input ready);
    modport sink (input valid, input func, input entry_payload, input entry_units,
                  output ready);
endinterface

>>> design/rdq_rsp_if.sv
// Result channel interface of the ring deque.
interface rdq_rsp_if;
    import rdq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [PAYLOAD_W-1:0] out_payload;
    logic [UNITS_W-1:0]   out_units;
    logic [COUNT_W-1:0]   entry_count;
    logic [LOAD_W-1:0]    total_load;

    modport source (output valid, output status, output out_payload, output out_units,
                    output entry_count, output total_load, input ready);
    modport sink (input valid, input status, input out_payload, input out_units,
                  input entry_count, input total_load, output ready);
endinterface

>>> design/rdq_ram.sv
// Generic simple dual-port RAM with a registered, enabled read port.
module rdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds when not enabled.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/rdq_ctrl.sv
// Front stage: decodes a request, keeps head, tail and count, drives the RAM.
module rdq_ctrl #(
    parameter int QUEUE_SLOTS = rdq_pkg::SLOTS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [rdq_pkg::FUNC_W-1:0]     func,
    input  logic [rdq_pkg::PAYLOAD_W-1:0]  entry_payload,
    input  logic [rdq_pkg::UNITS_W-1:0]    entry_units,
    input  logic                           advance,
    output logic                           ram_we,
    output logic [$clog2(QUEUE_SLOTS)-1:0] ram_waddr,
    output logic [rdq_pkg::ENTRY_W-1:0]    ram_wdata,
    output logic                           ram_re,
    output logic [$clog2(QUEUE_SLOTS)-1:0] ram_raddr,
    output logic                           stage_valid,
    output rdq_pkg::stage_t                stage
);
    import rdq_pkg::*;

    localparam int IW = $clog2(QUEUE_SLOTS);
    localparam logic [IW-1:0] LAST = IW'(QUEUE_SLOTS - 1);

    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [IW-1:0] count_reg, count_next;
    logic          stage_valid_reg, stage_valid_next;
    stage_t        stage_reg, stage_next;
    logic          accept;
    logic          full;
    logic          empty;
    logic          wr;
    logic          rd;
    logic [IW-1:0] wr_slot;
    logic [IW-1:0] rd_slot;

    function automatic logic [IW-1:0] step_fwd(input logic [IW-1:0] i);
        return (i == LAST) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IW-1:0] step_back(input logic [IW-1:0] i);
        return (i == '0) ? LAST : i - 1'b1;
    endfunction

    // A new transaction enters when the stage is empty or moves on.
    assign in_ready = !stage_valid_reg || advance;
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg >= LAST);
    assign empty    = (count_reg == '0);

    // Request decode and index updates.
    always_comb
    begin
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        wr                = 1'b0;
        rd                = 1'b0;
        wr_slot           = tail_reg;
        rd_slot           = head_reg;
        stage_next.push   = 1'b0;
        stage_next.pop    = 1'b0;
        stage_next.read   = 1'b0;
        stage_next.status = ST_DONE;
        stage_next.units  = entry_units;
        case (func_t'(func))
            FN_PUSH_BACK:
            begin
                if (full)
                begin
                    stage_next.status = ST_FULL;
                end
                else
                begin
                    wr              = 1'b1;
                    wr_slot         = tail_reg;
                    tail_next       = step_fwd(tail_reg);
                    count_next      = count_reg + 1'b1;
                    stage_next.push = 1'b1;
                end
            end
            FN_PUSH_FRONT:
            begin
                if (full)
                begin
                    stage_next.status = ST_FULL;
                end
                else
                begin
                    wr              = 1'b1;
                    wr_slot         = step_back(head_reg);
                    head_next       = step_back(head_reg);
                    count_next      = count_reg + 1'b1;
                    stage_next.push = 1'b1;
                end
            end
            FN_POP_FRONT:
            begin
                if (empty)
                begin
                    stage_next.status = ST_EMPTY;
                end
                else
                begin
                    rd              = 1'b1;
                    rd_slot         = head_reg;
                    head_next       = step_fwd(head_reg);
                    count_next      = count_reg - 1'b1;
                    stage_next.pop  = 1'b1;
                    stage_next.read = 1'b1;
                end
            end
            FN_POP_BACK:
            begin
                if (empty)
                begin
                    stage_next.status = ST_EMPTY;
                end
                else
                begin
                    rd              = 1'b1;
                    rd_slot         = step_back(tail_reg);
                    tail_next       = step_back(tail_reg);
                    count_next      = count_reg - 1'b1;
                    stage_next.pop  = 1'b1;
                    stage_next.read = 1'b1;
                end
            end
            FN_PEEK_FRONT:
            begin
                if (empty)
                begin
                    stage_next.status = ST_EMPTY;
                end
                else
                begin
                    rd              = 1'b1;
                    rd_slot         = head_reg;
                    stage_next.read = 1'b1;
                end
            end
            FN_PEEK_BACK:
            begin
                if (empty)
                begin
                    stage_next.status = ST_EMPTY;
                end
                else
                begin
                    rd              = 1'b1;
                    rd_slot         = step_back(tail_reg);
                    stage_next.read = 1'b1;
                end
            end
            default:
            begin
                stage_next.status = ST_DONE;
            end
        endcase
        stage_next.count = COUNT_W'(count_next);
    end

    // Stage occupancy.
    always_comb
    begin
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            if (accept)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
        end
    end

    // Stage payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
    end

    assign ram_we      = accept && wr;
    assign ram_waddr   = wr_slot;
    assign ram_wdata   = {entry_payload, entry_units};
    assign ram_re      = accept && rd;
    assign ram_raddr   = rd_slot;
    assign stage_valid = stage_valid_reg;
    assign stage       = stage_reg;

endmodule

>>> design/rdq_out.sv
// Result stage: keeps the load sum and holds the result register.
module rdq_out (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           stage_valid,
    input  rdq_pkg::stage_t                stage,
    input  logic [rdq_pkg::ENTRY_W-1:0]    ram_rdata,
    output logic                           advance,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rdq_pkg::STATUS_W-1:0]   status,
    output logic [rdq_pkg::PAYLOAD_W-1:0]  out_payload,
    output logic [rdq_pkg::UNITS_W-1:0]    out_units,
    output logic [rdq_pkg::COUNT_W-1:0]    entry_count,
    output logic [rdq_pkg::LOAD_W-1:0]     total_load
);
    import rdq_pkg::*;

    logic                 out_valid_reg, out_valid_next;
    logic [LOAD_W-1:0]    load_reg, load_next;
    logic [PAYLOAD_W-1:0] rd_payload;
    logic [UNITS_W-1:0]   rd_units;
    status_t              status_reg;
    logic [PAYLOAD_W-1:0] payload_reg;
    logic [UNITS_W-1:0]   units_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [LOAD_W-1:0]    total_reg;

    // The stage moves on when the result register is free or being taken.
    assign advance = stage_valid && (!out_valid_reg || out_ready);

    assign rd_payload = ram_rdata[ENTRY_W-1:UNITS_W];
    assign rd_units   = ram_rdata[UNITS_W-1:0];

    // Running load: pushes add their units, pops take off the stored units.
    always_comb
    begin
        load_next = load_reg;
        if (stage.push)
        begin
            load_next = load_reg + LOAD_W'(stage.units);
        end
        else if (stage.pop)
        begin
            load_next = load_reg - LOAD_W'(rd_units);
        end
    end

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            load_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                load_reg <= load_next;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg  <= stage.status;
            payload_reg <= stage.read ? rd_payload : '0;
            units_reg   <= stage.read ? rd_units : '0;
            count_reg   <= stage.count;
            total_reg   <= load_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_payload = payload_reg;
    assign out_units   = units_reg;
    assign entry_count = count_reg;
    assign total_load  = total_reg;

endmodule

>>> design/ring_deque_with_load_sum.sv
// Top level of the ring deque with a running sum of entry units.
//
//   channel  direction  payload
//   req      in         func, entry_payload, entry_units
//   rsp      out        status, out_payload, out_units, entry_count, total_load
//
// A request goes from the middle stage register, beside the registered RAM
// read, into the result register; one transaction per cycle is sustained while
// the result is not stalled, set by the index update and the RAM read port.
// Reset clears indices, count, load sum and valid flags; the RAM is not cleared.
// A stalled result holds the middle stage, and then req.ready stays low.
`include "ring_deque_with_load_sum_defines.svh"

module ring_deque_with_load_sum #(
    parameter int QUEUE_SLOTS = rdq_pkg::SLOTS_DEFAULT
) (
    input logic      clk,
    input logic      rst_n,
    rdq_req_if.sink  req,
    rdq_rsp_if.source rsp
);
    import rdq_pkg::*;

    localparam int IW = $clog2(QUEUE_SLOTS);

    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               stage_valid;
    stage_t             stage;
    logic               advance;

    // Request decode and index state.
    rdq_ctrl #(
        .QUEUE_SLOTS(QUEUE_SLOTS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (req.valid),
        .in_ready     (req.ready),
        .func         (req.func),
        .entry_payload(req.entry_payload),
        .entry_units  (req.entry_units),
        .advance      (advance),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .stage_valid  (stage_valid),
        .stage        (stage)
    );

    // Entry store.
    rdq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_SLOTS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Load sum and result register.
    rdq_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .stage_valid(stage_valid),
        .stage      (stage),
        .ram_rdata  (ram_rdata),
        .advance    (advance),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .status     (rsp.status),
        .out_payload(rsp.out_payload),
        .out_units  (rsp.out_units),
        .entry_count(rsp.entry_count),
        .total_load (rsp.total_load)
    );

    // A write and a read of the entry store never fall in the same cycle.
    `RDQ_ASSERT_SAME(a_no_rw_overlap, ram_we, !ram_re, "RAM read and write in one cycle")
    // A refused push reports a queue that is at capacity.
    `RDQ_ASSERT_SAME(a_full_count, rsp.valid && (rsp.status == ST_FULL),
        rsp.entry_count == COUNT_W'(QUEUE_SLOTS - 1), "full status with wrong count")
    // An empty queue carries no load.
    `RDQ_ASSERT_SAME(a_empty_load, rsp.valid && (rsp.status == ST_EMPTY),
        (rsp.entry_count == '0) && (rsp.total_load == '0), "empty status with load")
    // A held middle stage blocks new requests.
    `RDQ_ASSERT_SAME(a_stall_blocks, stage_valid && !advance, !req.ready,
        "request accepted over a held stage")
    // A stalled result stays valid in the next cycle.
    `RDQ_ASSERT_NEXT(a_rsp_hold, rsp.valid && !rsp.ready, rsp.valid, "stalled result dropped")

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the ring deque with a running load sum.
module tb_top;
    import rdq_pkg::*;

    localparam int QUEUE_SLOTS = SLOTS_DEFAULT;
    localparam int RANDOM_OPS_PER_PHASE = 165;

    // Function codes that the block leaves unused; such requests change nothing.
    localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic [UNITS_W-1:0]   units;
    } deque_entry_t;

    typedef struct packed {
        status_t              status;
        logic [PAYLOAD_W-1:0] payload;
        logic [UNITS_W-1:0]   units;
        logic [COUNT_W-1:0]   count;
        logic [LOAD_W-1:0]    load;
    } deque_result_t;

    // Keeps a copy of the deque contents and the results that accepted
    // requests are owed, and compares each returned transaction against them.
    class deque_scoreboard;
        deque_entry_t  contents[$];
        deque_result_t owed[$];
        int unsigned   load_sum;
        int unsigned   max_entries;
        int unsigned   failures;

        function new(int unsigned slots);
            max_entries = slots - 1;
            load_sum    = 0;
            failures    = 0;
        endfunction

        function void note_request(logic [FUNC_W-1:0] func, logic [PAYLOAD_W-1:0] payload,
                                   logic [UNITS_W-1:0] units);
            deque_result_t r;
            deque_entry_t  e;
            r = '0;
            r.status = ST_DONE;
            case (func)
                FN_PUSH_BACK, FN_PUSH_FRONT:
                begin
                    if (contents.size() >= max_entries)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        e.payload = payload;
                        e.units   = units;
                        if (func == FN_PUSH_BACK)
                            contents.push_back(e);
                        else
                            contents.push_front(e);
                        load_sum += units;
                    end
                end
                FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FRONT, FN_PEEK_BACK:
                begin
                    if (contents.size() == 0)
                    begin
                        r.status = ST_EMPTY;
                    end
                    else
                    begin
                        if (func == FN_POP_FRONT || func == FN_PEEK_FRONT)
                            e = contents[0];
                        else
                            e = contents[$];
                        r.payload = e.payload;
                        r.units   = e.units;
                        if (func == FN_POP_FRONT)
                            void'(contents.pop_front());
                        else if (func == FN_POP_BACK)
                            void'(contents.pop_back());
                        if (func == FN_POP_FRONT || func == FN_POP_BACK)
                            load_sum -= e.units;
                    end
                end
                default:
                begin
                end
            endcase
            r.count = COUNT_W'(contents.size());
            r.load  = LOAD_W'(load_sum);
            owed.push_back(r);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [PAYLOAD_W-1:0] payload,
                                   logic [UNITS_W-1:0] units, logic [COUNT_W-1:0] count,
                                   logic [LOAD_W-1:0] load);
            deque_result_t want;
            if (owed.size() == 0)
            begin
                $error("result transaction arrived with no request outstanding");
                failures++;
                return;
            end
            want = owed.pop_front();
            compare_field("status", 32'(want.status), 32'(status));
            compare_field("out_payload", want.payload, payload);
            compare_field("out_units", 32'(want.units), 32'(units));
            compare_field("entry_count", 32'(want.count), 32'(count));
            compare_field("total_load", 32'(want.load), 32'(load));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    rdq_req_if req ();
    rdq_rsp_if rsp ();

    ring_deque_with_load_sum #(
        .QUEUE_SLOTS(QUEUE_SLOTS)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    deque_scoreboard sb;
    int unsigned     send_idle_pct;
    int unsigned     stall_pct;
    int unsigned     counted_ops;

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard limit on the run time.
    initial
    begin
        #400000;
        $display("tb: failure");
        $finish;
    end

    // The receiver stalls at random according to the current phase.
    always @(negedge clk)
    begin
        rsp.ready = ($urandom_range(99) >= stall_pct);
    end

    // Both channels are observed at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
            sb.note_request(req.func, req.entry_payload, req.entry_units);
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_result(rsp.status, rsp.out_payload, rsp.out_units, rsp.entry_count,
                            rsp.total_load);
    end

    // Presents one request and returns at the falling edge after its acceptance.
    task automatic send_request(input logic [FUNC_W-1:0] func,
                                input logic [PAYLOAD_W-1:0] payload,
                                input logic [UNITS_W-1:0] units);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid = 1'b0;
            @(negedge clk);
        end
        req.valid         = 1'b1;
        req.func          = func;
        req.entry_payload = payload;
        req.entry_units   = units;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Issues an operation with random content; unused codes do not count.
    task automatic issue(input logic [FUNC_W-1:0] func);
        logic [UNITS_W-1:0] units;
        case ($urandom_range(3))
            0: units = '1;
            1: units = '0;
            default: units = UNITS_W'($urandom);
        endcase
        send_request(func, PAYLOAD_W'($urandom), units);
        if (func != FN_SPARE_6 && func != FN_SPARE_7)
            counted_ops++;
    endtask

    // Random traffic built from fill runs, drain runs, mixed runs and noise.
    task automatic run_random(input int unsigned ops);
        int unsigned kind;
        int unsigned len;
        int unsigned stop;
        stop = counted_ops + ops;
        while (counted_ops < stop)
        begin
            kind = $urandom_range(9);
            if (kind < 2)
            begin
                // Fill up to capacity, then push into a full deque.
                while (sb.contents.size() < QUEUE_SLOTS - 1)
                    issue($urandom_range(1) ? FN_PUSH_BACK : FN_PUSH_FRONT);
                len = $urandom_range(3, 1);
                repeat (len)
                    issue($urandom_range(1) ? FN_PUSH_BACK : FN_PUSH_FRONT);
            end
            else if (kind < 4)
            begin
                // Drain to empty with a few peeks, then access an empty deque.
                while (sb.contents.size() > 0)
                    issue(FUNC_W'($urandom_range(5, 2)));
                len = $urandom_range(2, 1);
                repeat (len)
                    issue(FUNC_W'($urandom_range(5, 2)));
            end
            else if (kind < 9)
            begin
                // Mixed operations around the current fill level.
                len = $urandom_range(30, 8);
                repeat (len)
                    issue(FUNC_W'($urandom_range(5)));
            end
            else
            begin
                // Noise, including the unused function codes.
                len = $urandom_range(4, 1);
                repeat (len)
                    issue(FUNC_W'($urandom_range(7)));
            end
        end
    endtask

    // Main sequence: reset, directed cases, then random phases.
    initial
    begin
        sb                = new(QUEUE_SLOTS);
        send_idle_pct     = 0;
        stall_pct         = 0;
        counted_ops       = 0;
        rst_n             = 1'b0;
        req.valid         = 1'b0;
        req.func          = '0;
        req.entry_payload = '0;
        req.entry_units   = '0;
        rsp.ready         = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Accesses on an empty deque and the unused codes.
        send_request(FN_POP_FRONT, 32'h1234_5678, 8'h12);
        send_request(FN_POP_BACK, 32'h0, 8'h0);
        send_request(FN_PEEK_FRONT, 32'hFFFF_FFFF, 8'hFF);
        send_request(FN_PEEK_BACK, 32'h0, 8'h0);
        send_request(FN_SPARE_6, 32'hFFFF_FFFF, 8'hFF);
        send_request(FN_SPARE_7, 32'h0, 8'h0);

        // Extreme payloads and weights from both ends.
        send_request(FN_PUSH_BACK, 32'hFFFF_FFFF, 8'hFF);
        send_request(FN_PUSH_FRONT, 32'h0, 8'h0);
        send_request(FN_PUSH_BACK, 32'hA5A5_A5A5, 8'h01);
        send_request(FN_PUSH_FRONT, 32'h8000_0001, 8'h80);
        send_request(FN_PEEK_FRONT, 32'h0, 8'h0);
        send_request(FN_PEEK_BACK, 32'h0, 8'h0);
        send_request(FN_POP_BACK, 32'h0, 8'h0);
        send_request(FN_POP_FRONT, 32'h0, 8'h0);
        send_request(FN_SPARE_7, 32'h5A5A_5A5A, 8'h7F);
        send_request(FN_PEEK_BACK, 32'h0, 8'h0);
        send_request(FN_POP_FRONT, 32'h0, 8'h0);
        send_request(FN_POP_BACK, 32'h0, 8'h0);
        send_request(FN_POP_BACK, 32'h0, 8'h0);

        // Random phases with different amounts of idling on each side.
        run_random(RANDOM_OPS_PER_PHASE);
        send_idle_pct = 71;
        stall_pct     = 0;
        run_random(RANDOM_OPS_PER_PHASE);
        send_idle_pct = 0;
        stall_pct     = 71;
        run_random(RANDOM_OPS_PER_PHASE);
        send_idle_pct = 6;
        stall_pct     = 6;
        run_random(RANDOM_OPS_PER_PHASE);

        // Drain outstanding results and let the pipeline settle.
        req.valid = 1'b0;
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (sb.failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/rdq_pkg.sv
design/rdq_req_if.sv
design/rdq_rsp_if.sv
design/rdq_ram.sv
design/rdq_ctrl.sv
design/rdq_out.sv
design/ring_deque_with_load_sum.sv
bench/tb_top.sv
